[design/btrn_pkg.sv]
// shared types, symbol table and constants for the binary to roman numeral block
`default_nettype none

package btrn_pkg;

   localparam int VALUE_W  = 12;
   localparam int SYMBOL_W = 7;
   localparam int SYM_COUNT = 13;
   localparam int IDX_W    = 4;
   localparam int Q_DEPTH  = 2;
   localparam int QPTR_W   = 1;
   localparam int QCNT_W   = 2;

   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [SYMBOL_W-1:0] symbol_type;
   typedef logic [IDX_W-1:0]    idx_type;

   // ascii letters of the numerals
   localparam symbol_type SYM_NONE = 7'h00;
   localparam symbol_type SYM_M    = 7'h4D;
   localparam symbol_type SYM_D    = 7'h44;
   localparam symbol_type SYM_C    = 7'h43;
   localparam symbol_type SYM_L    = 7'h4C;
   localparam symbol_type SYM_X    = 7'h58;
   localparam symbol_type SYM_V    = 7'h56;
   localparam symbol_type SYM_I    = 7'h49;

   // one queued item: the value and its front-side class
   typedef struct packed {
      value_type value;
      logic      zero;
   } item_type;

   // queue head as the back sees it
   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

   function automatic value_type sym_weight(input idx_type idx);
      value_type w;
      unique case (idx)
         4'd0:    w = 12'd1000;
         4'd1:    w = 12'd900;
         4'd2:    w = 12'd500;
         4'd3:    w = 12'd400;
         4'd4:    w = 12'd100;
         4'd5:    w = 12'd90;
         4'd6:    w = 12'd50;
         4'd7:    w = 12'd40;
         4'd8:    w = 12'd10;
         4'd9:    w = 12'd9;
         4'd10:   w = 12'd5;
         4'd11:   w = 12'd4;
         default: w = 12'd1;
      endcase
      return w;
   endfunction

   function automatic symbol_type sym_first(input idx_type idx);
      symbol_type s;
      unique case (idx)
         4'd0:    s = SYM_M;
         4'd1:    s = SYM_C;
         4'd2:    s = SYM_D;
         4'd3:    s = SYM_C;
         4'd4:    s = SYM_C;
         4'd5:    s = SYM_X;
         4'd6:    s = SYM_L;
         4'd7:    s = SYM_X;
         4'd8:    s = SYM_X;
         4'd9:    s = SYM_I;
         4'd10:   s = SYM_V;
         4'd11:   s = SYM_I;
         default: s = SYM_I;
      endcase
      return s;
   endfunction

   // second letter of a subtractive pair, none for single letters
   function automatic symbol_type sym_second(input idx_type idx);
      symbol_type s;
      unique case (idx)
         4'd1:    s = SYM_M;
         4'd3:    s = SYM_D;
         4'd5:    s = SYM_C;
         4'd7:    s = SYM_L;
         4'd9:    s = SYM_X;
         4'd11:   s = SYM_V;
         default: s = SYM_NONE;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

[design/btrn_front.sv]
// front end: accepts values, marks zero, and holds them in a two-entry queue
`default_nettype none

module btrn_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire btrn_pkg::value_type   req_value,
   output logic                       req_stall,
   input  wire logic                  pop,
   output btrn_pkg::q_head_type       head
);

   btrn_pkg::item_type                  mem_ff [btrn_pkg::Q_DEPTH];
   logic [btrn_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [btrn_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [btrn_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                                push;
   logic                                do_pop;
   btrn_pkg::item_type                  new_item;

   assign req_stall = (count_ff == btrn_pkg::QCNT_W'(btrn_pkg::Q_DEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   // classify at the door so the back only branches on one bit
   assign new_item = {req_value, (req_value == '0)};

   assign head = {(count_ff != '0), mem_ff[rd_ptr_ff]};

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

[design/btrn_back.sv]
// back end: greedy symbol walker, one letter per cycle into the result register while rsp_stall is low
`default_nettype none

module btrn_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire btrn_pkg::q_head_type  head,
   output logic                       pop,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output btrn_pkg::symbol_type       rsp_symbol,
   output logic                       rsp_last,
   output logic                       rsp_empty_res
);

   logic                  busy_ff, busy_in;
   logic                  pend_ff, pend_in;
   btrn_pkg::value_type   rest_ff, rest_in;
   btrn_pkg::symbol_type  second_ff, second_in;
   logic                  valid_ff, valid_in;
   btrn_pkg::symbol_type  symbol_ff, symbol_in;
   logic                  last_ff, last_in;
   logic                  empty_ff, empty_in;

   logic                  advance;
   btrn_pkg::value_type   src;
   btrn_pkg::idx_type     idx;
   btrn_pkg::value_type   rest_sub;
   btrn_pkg::symbol_type  pair_second;

   assign advance = !valid_ff || !rsp_stall;
   assign pop     = advance && !busy_ff && head.valid;
   assign src     = busy_ff ? rest_ff : head.item.value;

   // largest symbol that still fits
   always_comb begin
      idx = btrn_pkg::idx_type'(btrn_pkg::SYM_COUNT - 1);
      for (int i = btrn_pkg::SYM_COUNT - 1; i >= 0; i--) begin
         if (src >= btrn_pkg::sym_weight(btrn_pkg::idx_type'(i))) begin
            idx = btrn_pkg::idx_type'(i);
         end
      end
   end

   assign rest_sub    = src - btrn_pkg::sym_weight(idx);
   assign pair_second = btrn_pkg::sym_second(idx);

   always_comb begin
      busy_in   = busy_ff;
      pend_in   = pend_ff;
      rest_in   = rest_ff;
      second_in = second_ff;
      valid_in  = valid_ff;
      symbol_in = symbol_ff;
      last_in   = last_ff;
      empty_in  = empty_ff;
      if (advance) begin
         valid_in = 1'b0;
         priority if (busy_ff && pend_ff) begin
            valid_in  = 1'b1;
            symbol_in = second_ff;
            last_in   = (rest_ff == '0);
            empty_in  = 1'b0;
            pend_in   = 1'b0;
            busy_in   = (rest_ff != '0);
         end else if (busy_ff || (head.valid && !head.item.zero)) begin
            valid_in  = 1'b1;
            symbol_in = btrn_pkg::sym_first(idx);
            empty_in  = 1'b0;
            rest_in   = rest_sub;
            if (pair_second != btrn_pkg::SYM_NONE) begin
               last_in   = 1'b0;
               pend_in   = 1'b1;
               second_in = pair_second;
               busy_in   = 1'b1;
            end else begin
               last_in = (rest_sub == '0);
               busy_in = (rest_sub != '0);
            end
         end else if (head.valid) begin
            // zero value: one empty marker
            valid_in  = 1'b1;
            symbol_in = btrn_pkg::SYM_NONE;
            last_in   = 1'b1;
            empty_in  = 1'b1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
      rest_ff   <= rest_in;
      second_ff <= second_in;
      symbol_ff <= symbol_in;
      last_ff   <= last_in;
      empty_ff  <= empty_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_symbol    = symbol_ff;
   assign rsp_last      = last_ff;
   assign rsp_empty_res = empty_ff;

endmodule

`default_nettype wire

[design/binary_to_roman_numeral.sv]
// top level of the binary to roman numeral converter
//
// usage:
//   req channel: req_valid/req_stall with req_value, an unsigned 12-bit
//   number 0..4095; an item is taken at an edge with req_valid high and
//   req_stall low
//   rsp channel: rsp_valid/rsp_stall, one ascii letter per item in
//   rsp_symbol, rsp_last on the final letter of a value's run, and
//   rsp_empty_res (with rsp_symbol zero and rsp_last set) for a zero value
// a taken value is written into the queue, and its first letter is then
//   registered in the result register when the back end is free
// throughput: one letter per cycle from the greedy walker while rsp_stall is
//   low; a value gives 1 to 15 letters, or one empty marker for zero; the
//   next value starts in the cycle after the last letter leaves the walker
// the front end holds up to two values in its queue; req_stall rises
//   only when that queue is full
// when the receiver holds rsp_stall the result register keeps its item
//   and the walker waits; the front keeps taking items until the queue fills
// reset (synchronous, active high) empties the queue and drops any run
//   in progress; nothing else needs clearing
`default_nettype none

module binary_to_roman_numeral (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire btrn_pkg::value_type   req_value,
   output logic                       req_stall,
   output logic                       rsp_valid,
   output btrn_pkg::symbol_type       rsp_symbol,
   output logic                       rsp_last,
   output logic                       rsp_empty_res,
   input  wire logic                  rsp_stall
);

   // queue head and pop between front and back
   btrn_pkg::q_head_type head;
   logic                 pop;

   // accept, zero check and queueing
   btrn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_value (req_value),
      .req_stall (req_stall),
      .pop       (pop),
      .head      (head)
   );

   // letter generation and result register
   btrn_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_symbol    (rsp_symbol),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res)
   );

endmodule

`default_nettype wire

[design/btrn_checker.sv]
// port-level checks for the binary to roman numeral converter
`default_nettype none

module btrn_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire btrn_pkg::symbol_type rsp_symbol,
   input wire logic                 rsp_last,
   input wire logic                 rsp_empty_res,
   input wire logic                 rsp_stall
);

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_symbol)
                                 && $stable(rsp_last) && $stable(rsp_empty_res))
      else $error("stalled result changed");

   // empty marker is a lone last item with no letter
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && rsp_symbol == btrn_pkg::SYM_NONE)
      else $error("bad empty result");

   // every non-empty item is a numeral letter
   a_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_res |->
         rsp_symbol == btrn_pkg::SYM_M || rsp_symbol == btrn_pkg::SYM_D ||
         rsp_symbol == btrn_pkg::SYM_C || rsp_symbol == btrn_pkg::SYM_L ||
         rsp_symbol == btrn_pkg::SYM_X || rsp_symbol == btrn_pkg::SYM_V ||
         rsp_symbol == btrn_pkg::SYM_I)
      else $error("result is not a numeral letter");

   // once a value is taken, rsp_valid is high after the queue and result registers
   a_taken_shows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("taken value shows no result");

endmodule

bind binary_to_roman_numeral btrn_checker u_btrn_checker (.*);

`default_nettype wire
